// ===== hdl/csfw_pkg.sv =====
// Shared types and codes for the counting semaphore with a waiter queue.
// No dependencies; imported by csfw_ctrl, csfw_outq and the top unit.
package csfw_pkg;

  localparam int ID_W    = 16;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_ACQUIRE = 1'b1;

  localparam logic [1:0] ST_ACK    = 2'd0;
  localparam logic [1:0] ST_GRANT  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // One decided request waiting to be turned into results.
  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] id;
    logic            pair;    // a hand-over grant follows the acknowledge
  } csfw_item_t;

endpackage

// ===== hdl/csfw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/csfw_ctrl.sv =====
// Semaphore count, waiter ring control and the decision register.
// Depends on csfw_pkg and csfw_ram.
module csfw_ctrl import csfw_pkg::*; #(
  parameter int QUEUE_DEPTH = 4,
  parameter int ID_BITS     = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic            req_op,
  input  logic [ID_W-1:0] req_id,
  output logic            item_valid,
  output csfw_item_t      item,
  output logic [ID_W-1:0] grant_id,
  input  logic            take
);

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = ADDR_W + 1;

  logic [COUNT_W-1:0] count, count_next;
  logic [ADDR_W-1:0]  head, head_next;
  logic [OCC_W-1:0]   occ, occ_next;
  logic               item_valid_next;
  csfw_item_t         item_next;

  logic               accept;
  logic               has_wait, queue_full;
  logic               push, pop;
  logic [SUM_W-1:0]   tail_sum;
  logic [ADDR_W-1:0]  tail;
  logic [ID_BITS-1:0] id_store;
  logic [ID_W-1:0]    id_back;
  logic [ID_BITS-1:0] rd_data;

  if (ID_BITS >= ID_W) begin : g_wide_id
    assign id_store = ID_BITS'(req_id);
    assign id_back  = id_store[ID_W-1:0];
    assign grant_id = rd_data[ID_W-1:0];
  end else begin : g_narrow_id
    assign id_store = req_id[ID_BITS-1:0];
    assign id_back  = ID_W'(id_store);
    assign grant_id = ID_W'(rd_data);
  end

  assign req_ready  = !item_valid || take;
  assign accept     = req_valid && req_ready;
  assign has_wait   = (occ != '0);
  assign queue_full = (occ == OCC_W'(QUEUE_DEPTH));

  assign pop  = accept && (req_op == OP_RELEASE) && has_wait;
  assign push = accept && (req_op == OP_ACQUIRE) && (count == '0) && !queue_full;

  // The tail wraps at most once, so one compare and subtract is enough.
  assign tail_sum = {1'b0, head} + SUM_W'(occ);
  always_comb begin
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = ADDR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = ADDR_W'(tail_sum);
    end
  end

  always_comb begin
    count_next      = count;
    head_next       = head;
    occ_next        = occ;
    item_valid_next = item_valid && !take;
    item_next       = item;
    if (accept) begin
      item_valid_next = 1'b1;
      item_next.id    = id_back;
      item_next.pair  = 1'b0;
      if (req_op == OP_RELEASE) begin
        item_next.status = ST_ACK;
        if (has_wait) begin
          item_next.pair = 1'b1;
          occ_next       = occ - OCC_W'(1);
          if (head == ADDR_W'(QUEUE_DEPTH - 1)) begin
            head_next = '0;
          end else begin
            head_next = head + ADDR_W'(1);
          end
        end else if (count != COUNT_MAX) begin
          count_next = count + COUNT_W'(1);
        end
      end else if (count != '0) begin
        item_next.status = ST_GRANT;
        count_next       = count - COUNT_W'(1);
      end else if (!queue_full) begin
        // Queued without a result.
        item_valid_next = 1'b0;
        occ_next        = occ + OCC_W'(1);
      end else begin
        item_next.status = ST_REJECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      head       <= '0;
      occ        <= '0;
      item_valid <= 1'b0;
    end else begin
      count      <= count_next;
      head       <= head_next;
      occ        <= occ_next;
      item_valid <= item_valid_next;
    end
    item <= item_next;
  end

  csfw_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail),
    .wr_data (id_store),
    .rd_en   (pop),
    .rd_addr (head),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  // Requesters only wait while no unit is free.
  a_wait_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (occ == '0))
    else $error("waiters present while the count is nonzero");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_pop_pairs: assert property (@(posedge clk) disable iff (rst)
    pop |=> (item_valid && item.pair && item.status == ST_ACK))
    else $error("hand-over without a paired acknowledge");
`endif

endmodule

// ===== hdl/csfw_outq.sv =====
// Result register that sends one or two results for each decided request.
// Depends on csfw_pkg.
module csfw_outq import csfw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  csfw_item_t      item,
  input  logic [ID_W-1:0] grant_id,
  output logic            take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [ID_W-1:0] out_id,
  output logic            out_last
);

  logic            second;
  logic [ID_W-1:0] grant_q;
  logic            free;

  // The register frees up once its final result of the request goes out.
  assign free = !out_valid || (out_ready && !second);
  assign take = item_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
      second    <= item.pair;
    end else if (out_valid && out_ready) begin
      if (!second) begin
        out_valid <= 1'b0;
      end
      second <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= item.status;
      out_id     <= item.id;
      out_last   <= !item.pair;
      grant_q    <= grant_id;
    end else if (out_valid && out_ready && second) begin
      out_status <= ST_GRANT;
      out_id     <= grant_q;
      out_last   <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_grant_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_last && out_status == ST_GRANT))
    else $error("acknowledge not followed by the hand-over grant");

  a_second_tracks_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second == !out_last))
    else $error("pending grant flag out of step with last");
`endif

endmodule

// ===== hdl/counting_semaphore_fifo_waiters_unit.sv =====
// Channel  Dir  tdata              tuser           tlast
// s_       in   requester_id[15:0] op[0]           -
// m_       out  target_id[15:0]    status[1:0]     last result of a request
//
// A request is decided in the cycle it is accepted and lands in a decision
// register at the accepting edge; its first result moves into the result
// register once that register is free, and shows on m_ from there.
// Each request gives one result, except a release that hands a unit to a
// waiter, which gives an acknowledge and then a grant.
// A queued acquire gives no result.
// Reset is synchronous and clears the count and queue pointers; stalls on
// m_tready back up through the result register into s_tready.
// Depends on csfw_pkg, csfw_ctrl, csfw_outq and csfw_ram.
module counting_semaphore_fifo_waiters_unit import csfw_pkg::*; #(
  parameter int QUEUE_DEPTH = 4,
  parameter int ID_BITS     = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [ID_W-1:0] s_tdata,   // requester_id
  input  logic [0:0]      s_tuser,   // op
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [ID_W-1:0] m_tdata,   // target_id
  output logic [1:0]      m_tuser,   // status
  output logic            m_tlast
);

  logic            item_valid;
  csfw_item_t      item;
  logic [ID_W-1:0] grant_id;
  logic            take;

  csfw_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_op     (s_tuser[0]),
    .req_id     (s_tdata),
    .item_valid (item_valid),
    .item       (item),
    .grant_id   (grant_id),
    .take       (take)
  );

  csfw_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .grant_id   (grant_id),
    .take       (take),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_id     (m_tdata),
    .out_last   (m_tlast)
  );

endmodule
